// ===== rtl/hgph_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgph_pkg: shared types and constants
// Widths, codes, register indexes and command/status structs for the
// hysteresis-gated PID heater controller.
// ----------------------------------------------------------------------------
package hgph_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int TEMP_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int PERIOD_W    = 16;
    localparam int ERR_W       = 17;
    localparam int INTEG_W     = 17;
    localparam int DIFF_W      = 18;
    localparam int DERIV_W     = 19;
    localparam int ACC_W       = 38;
    localparam int MUL_W       = 24;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DUTY_W      = 15;
    localparam int CMP_W       = 17;
    localparam int X_W         = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // duty full scale is 100 << FRAC_BITS = 25 << (FRAC_BITS + 2)
    localparam logic [DUTY_W-1:0] FULL_DUTY   = DUTY_W'(100 << FRAC_BITS);
    localparam int                DIV_SHIFT   = FRAC_BITS + 2;
    localparam int                DIV_ODD     = 25;
    localparam int                RECIP_SHIFT = 24;
    localparam logic [19:0]       RECIP_CONST = 20'((1 << RECIP_SHIFT) / DIV_ODD);

    typedef enum logic [1:0] {
        MODE_PID      = 2'd0,
        MODE_OFF_HIGH = 2'd1,
        MODE_OFF_BAND = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REFERENCE = 3'd0,
        REG_UPPER     = 3'd1,
        REG_LOWER     = 3'd2,
        REG_GAIN_P    = 3'd3,
        REG_GAIN_I    = 3'd4,
        REG_GAIN_D    = 3'd5,
        REG_LIMIT     = 3'd6,
        REG_PERIOD    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TEMP_W-1:0]   reference_temp;
        logic [TEMP_W-1:0]   thresh_high;
        logic [TEMP_W-1:0]   thresh_low;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [LIMIT_W-1:0]  integral_limit;
        logic [PERIOD_W-1:0] pwm_period;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_CMP,
        MUL_RECIP,
        MUL_BACK
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_DUTY,
        ST_CMP_MUL,
        ST_RECIP_MUL,
        ST_BACK_MUL,
        ST_CORRECT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     classify;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     load_duty;
        logic     load_x;
        logic     load_q0;
        logic     load_cmp;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic pid;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/hgph_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgph_cfg: configuration register file
// Eight registers written by index over a valid/ready channel.
// ----------------------------------------------------------------------------
module hgph_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hgph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hgph_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hgph_pkg::cfg_t                        cfg
);

    hgph_pkg::cfg_t cfg_reg;
    hgph_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (hgph_pkg::cfg_idx_t'(cfg_index))
                hgph_pkg::REG_REFERENCE: cfg_next.reference_temp  = cfg_data;
                hgph_pkg::REG_UPPER:     cfg_next.thresh_high     = cfg_data;
                hgph_pkg::REG_LOWER:     cfg_next.thresh_low      = cfg_data;
                hgph_pkg::REG_GAIN_P:    cfg_next.gain_p          = cfg_data;
                hgph_pkg::REG_GAIN_I:    cfg_next.gain_i          = cfg_data;
                hgph_pkg::REG_GAIN_D:    cfg_next.gain_d          = cfg_data;
                hgph_pkg::REG_LIMIT:
                    cfg_next.integral_limit = cfg_data[hgph_pkg::LIMIT_W-1:0];
                hgph_pkg::REG_PERIOD:    cfg_next.pwm_period      = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference_temp  <= 16'd7680;
            cfg_reg.thresh_high     <= 16'd7680;
            cfg_reg.thresh_low      <= 16'd7629;
            cfg_reg.gain_p          <= 16'd5120;
            cfg_reg.gain_i          <= 16'd512;
            cfg_reg.gain_d          <= 16'd2560;
            cfg_reg.integral_limit  <= 15'd12800;
            cfg_reg.pwm_period      <= 16'd99;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hgph_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgph_ctrl: sequencing state machine
// Steps one sample through classification, the shared multiplier and the
// output register.
// ----------------------------------------------------------------------------
module hgph_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  hgph_pkg::status_t      status,
    output hgph_pkg::cmd_t         cmd
);

    hgph_pkg::state_t state_reg;
    hgph_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hgph_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = hgph_pkg::ST_CLASSIFY;
                end
            hgph_pkg::ST_CLASSIFY:
                state_next = status.pid ? hgph_pkg::ST_MUL_P : hgph_pkg::ST_FINISH;
            hgph_pkg::ST_MUL_P:     state_next = hgph_pkg::ST_MUL_I;
            hgph_pkg::ST_MUL_I:     state_next = hgph_pkg::ST_MUL_D;
            hgph_pkg::ST_MUL_D:     state_next = hgph_pkg::ST_SUM;
            hgph_pkg::ST_SUM:       state_next = hgph_pkg::ST_DUTY;
            hgph_pkg::ST_DUTY:      state_next = hgph_pkg::ST_CMP_MUL;
            hgph_pkg::ST_CMP_MUL:   state_next = hgph_pkg::ST_RECIP_MUL;
            hgph_pkg::ST_RECIP_MUL: state_next = hgph_pkg::ST_BACK_MUL;
            hgph_pkg::ST_BACK_MUL:  state_next = hgph_pkg::ST_CORRECT;
            hgph_pkg::ST_CORRECT:   state_next = hgph_pkg::ST_FINISH;
            hgph_pkg::ST_FINISH:
                if (status.out_free)
                begin
                    state_next = hgph_pkg::ST_IDLE;
                end
            default:                state_next = hgph_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != hgph_pkg::ST_IDLE);
        unique case (state_reg)
            hgph_pkg::ST_IDLE:      cmd.load_in  = in_valid;
            hgph_pkg::ST_CLASSIFY:  cmd.classify = 1'b1;
            hgph_pkg::ST_MUL_P:     cmd.mul_sel  = hgph_pkg::MUL_P;
            hgph_pkg::ST_MUL_I:
            begin
                cmd.mul_sel  = hgph_pkg::MUL_I;
                cmd.acc_load = 1'b1;
            end
            hgph_pkg::ST_MUL_D:
            begin
                cmd.mul_sel = hgph_pkg::MUL_D;
                cmd.acc_add = 1'b1;
            end
            hgph_pkg::ST_SUM:       cmd.acc_add   = 1'b1;
            hgph_pkg::ST_DUTY:      cmd.load_duty = 1'b1;
            hgph_pkg::ST_CMP_MUL:   cmd.mul_sel   = hgph_pkg::MUL_CMP;
            hgph_pkg::ST_RECIP_MUL:
            begin
                cmd.mul_sel = hgph_pkg::MUL_RECIP;
                cmd.load_x  = 1'b1;
            end
            hgph_pkg::ST_BACK_MUL:
            begin
                cmd.mul_sel = hgph_pkg::MUL_BACK;
                cmd.load_q0 = 1'b1;
            end
            hgph_pkg::ST_CORRECT:   cmd.load_cmp = 1'b1;
            hgph_pkg::ST_FINISH:    cmd.out_load = status.out_free;
            default:                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hgph_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hgph_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgph_dpath: controller datapath
// Hysteresis classification, integral and derivative state, one shared
// signed multiplier, accumulator, duty saturation, compare scaling and the
// output register.
// ----------------------------------------------------------------------------
module hgph_dpath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  hgph_pkg::cfg_t                      cfg,
    input  hgph_pkg::cmd_t                      cmd,
    output hgph_pkg::status_t                   status,
    input  wire logic [hgph_pkg::TEMP_W-1:0]    measured_temp,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [hgph_pkg::DUTY_W-1:0]         duty_percent,
    output logic [hgph_pkg::CMP_W-1:0]          compare_value,
    output logic [1:0]                          regulation_mode
);

    localparam int IRAW_W = hgph_pkg::INTEG_W + 1;
    localparam int SHR_W  = hgph_pkg::ACC_W - hgph_pkg::FRAC_BITS;

    logic [hgph_pkg::TEMP_W-1:0]           m_reg;
    logic signed [hgph_pkg::ERR_W-1:0]     err_reg;
    logic signed [hgph_pkg::INTEG_W-1:0]   integ_reg;
    logic signed [hgph_pkg::DERIV_W-1:0]   deriv_reg;
    logic signed [hgph_pkg::INTEG_W-1:0]   isum_reg;
    logic signed [hgph_pkg::ERR_W-1:0]     perr_reg;
    logic signed [hgph_pkg::PROD_W-1:0]    prod_reg;
    logic signed [hgph_pkg::ACC_W-1:0]     acc_reg;
    logic [hgph_pkg::X_W-1:0]              x_reg;
    logic [hgph_pkg::CMP_W-1:0]            q0_reg;
    logic [hgph_pkg::DUTY_W-1:0]           duty_res_reg;
    logic [hgph_pkg::CMP_W-1:0]            cmp_res_reg;
    hgph_pkg::mode_t                       mode_res_reg;
    logic                                  out_valid_reg;
    logic [hgph_pkg::DUTY_W-1:0]           duty_out_reg;
    logic [hgph_pkg::CMP_W-1:0]            cmp_out_reg;
    hgph_pkg::mode_t                       mode_out_reg;

    hgph_pkg::mode_t                       mode_next;
    logic signed [hgph_pkg::ERR_W-1:0]     err_next;
    logic signed [hgph_pkg::ERR_W-1:0]     half_err;
    logic signed [IRAW_W-1:0]              integ_raw;
    logic signed [IRAW_W-1:0]              lim_pos;
    logic signed [hgph_pkg::INTEG_W-1:0]   integ_next;
    logic signed [hgph_pkg::DIFF_W-1:0]    diff;
    logic signed [hgph_pkg::DERIV_W-1:0]   deriv_next;
    logic signed [hgph_pkg::MUL_W-1:0]     mul_a;
    logic signed [hgph_pkg::MUL_W-1:0]     mul_b;
    logic signed [hgph_pkg::PROD_W-1:0]    prod_next;
    logic signed [hgph_pkg::ACC_W-1:0]     prod_acc;
    logic [SHR_W-1:0]                      acc_shr;
    logic [hgph_pkg::DUTY_W-1:0]           duty_next;
    logic [hgph_pkg::X_W-1:0]              x_next;
    logic [hgph_pkg::CMP_W-1:0]            q0_next;
    logic [hgph_pkg::X_W-1:0]              rem;
    logic [hgph_pkg::CMP_W-1:0]            cmp_next;

    // hysteresis classification, upper test first
    always_comb
    begin
        if (m_reg >= cfg.thresh_high)
        begin
            mode_next = hgph_pkg::MODE_OFF_HIGH;
        end
        else if (m_reg <= cfg.thresh_low)
        begin
            mode_next = hgph_pkg::MODE_PID;
        end
        else
        begin
            mode_next = hgph_pkg::MODE_OFF_BAND;
        end
    end

    assign err_next  = $signed({1'b0, cfg.reference_temp}) - $signed({1'b0, m_reg});
    assign half_err  = err_next >>> 1;
    assign integ_raw = IRAW_W'(isum_reg) + IRAW_W'(half_err);
    assign lim_pos   = $signed({{(IRAW_W - hgph_pkg::LIMIT_W){1'b0}}, cfg.integral_limit});

    always_comb
    begin
        priority if (integ_raw > lim_pos)
        begin
            integ_next = hgph_pkg::INTEG_W'(lim_pos);
        end
        else if (integ_raw < -lim_pos)
        begin
            integ_next = hgph_pkg::INTEG_W'(-lim_pos);
        end
        else
        begin
            integ_next = hgph_pkg::INTEG_W'(integ_raw);
        end
    end

    assign diff       = hgph_pkg::DIFF_W'(err_next) - hgph_pkg::DIFF_W'(perr_reg);
    assign deriv_next = {diff, 1'b0};

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            hgph_pkg::MUL_P:
            begin
                mul_a = hgph_pkg::MUL_W'($signed({1'b0, cfg.gain_p}));
                mul_b = hgph_pkg::MUL_W'(err_reg);
            end
            hgph_pkg::MUL_I:
            begin
                mul_a = hgph_pkg::MUL_W'($signed({1'b0, cfg.gain_i}));
                mul_b = hgph_pkg::MUL_W'(integ_reg);
            end
            hgph_pkg::MUL_D:
            begin
                mul_a = hgph_pkg::MUL_W'($signed({1'b0, cfg.gain_d}));
                mul_b = hgph_pkg::MUL_W'(deriv_reg);
            end
            hgph_pkg::MUL_CMP:
            begin
                mul_a = hgph_pkg::MUL_W'($signed({1'b0, duty_res_reg}));
                mul_b = hgph_pkg::MUL_W'($signed({1'b0, cfg.pwm_period}) + 18'sd1);
            end
            hgph_pkg::MUL_RECIP:
            begin
                mul_a = hgph_pkg::MUL_W'($signed({1'b0, x_next}));
                mul_b = hgph_pkg::MUL_W'($signed({1'b0, hgph_pkg::RECIP_CONST}));
            end
            hgph_pkg::MUL_BACK:
            begin
                mul_a = hgph_pkg::MUL_W'($signed({1'b0, q0_next}));
                mul_b = hgph_pkg::MUL_W'(hgph_pkg::DIV_ODD);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_acc  = $signed(prod_reg[hgph_pkg::ACC_W-1:0]);

    // saturate duty to 0..full scale
    assign acc_shr = acc_reg[hgph_pkg::ACC_W-1:hgph_pkg::FRAC_BITS];

    always_comb
    begin
        priority if (acc_reg[hgph_pkg::ACC_W-1] || (acc_reg == '0))
        begin
            duty_next = '0;
        end
        else if (acc_shr > SHR_W'(hgph_pkg::FULL_DUTY))
        begin
            duty_next = hgph_pkg::FULL_DUTY;
        end
        else
        begin
            duty_next = acc_shr[hgph_pkg::DUTY_W-1:0];
        end
    end

    // divide by full scale: shift, reciprocal multiply, one-step correction
    assign x_next   = prod_reg[hgph_pkg::DIV_SHIFT +: hgph_pkg::X_W];
    assign q0_next  = prod_reg[hgph_pkg::RECIP_SHIFT +: hgph_pkg::CMP_W];
    assign rem      = x_reg - prod_reg[hgph_pkg::X_W-1:0];
    assign cmp_next = (rem >= hgph_pkg::X_W'(hgph_pkg::DIV_ODD)) ? q0_reg + 1'b1 : q0_reg;

    assign status.pid      = (mode_next == hgph_pkg::MODE_PID);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            m_reg <= measured_temp;
        end
        if (cmd.classify)
        begin
            mode_res_reg <= mode_next;
            err_reg      <= err_next;
            integ_reg    <= integ_next;
            deriv_reg    <= deriv_next;
            if (mode_next != hgph_pkg::MODE_PID)
            begin
                duty_res_reg <= '0;
                cmp_res_reg  <= '0;
            end
        end
        if (cmd.mul_sel != hgph_pkg::MUL_HOLD)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_acc;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_acc;
        end
        if (cmd.load_duty)
        begin
            duty_res_reg <= duty_next;
        end
        if (cmd.load_x)
        begin
            x_reg <= x_next;
        end
        if (cmd.load_q0)
        begin
            q0_reg <= q0_next;
        end
        if (cmd.load_cmp)
        begin
            cmp_res_reg <= cmp_next;
        end
        if (cmd.out_load)
        begin
            duty_out_reg <= duty_res_reg;
            cmp_out_reg  <= cmp_res_reg;
            mode_out_reg <= mode_res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isum_reg      <= '0;
            perr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.classify)
            begin
                if (mode_next == hgph_pkg::MODE_PID)
                begin
                    isum_reg <= integ_next;
                    perr_reg <= err_next;
                end
                else
                begin
                    isum_reg <= '0;
                    perr_reg <= '0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign duty_percent    = duty_out_reg;
    assign compare_value   = cmp_out_reg;
    assign regulation_mode = mode_out_reg;

endmodule
`default_nettype wire

// ===== rtl/hysteresis_gated_pid_heater.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hysteresis_gated_pid_heater: hysteresis-gated PID heater controller
// A heating sample steps through classify, the P, I, D multiplies, sum, duty,
// the compare, reciprocal and back multiplies, correction and finish; an off
// sample goes from classify to finish. One shared 24x24 multiplier is used six
// times in sequence. The next sample is taken once the last has been loaded
// into the output register, while that result may still wait there.
// Reset clears the integral and previous error and loads register defaults.
// ----------------------------------------------------------------------------
module hysteresis_gated_pid_heater (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [hgph_pkg::TEMP_W-1:0]      measured_temp,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [hgph_pkg::DUTY_W-1:0]           duty_percent,
    output logic [hgph_pkg::CMP_W-1:0]            compare_value,
    output logic [1:0]                            regulation_mode,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hgph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hgph_pkg::CFG_DATA_W-1:0]  cfg_data
);

    hgph_pkg::cfg_t    cfg;
    hgph_pkg::cmd_t    cmd;
    hgph_pkg::status_t status;

    hgph_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hgph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hgph_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .measured_temp   (measured_temp),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .duty_percent    (duty_percent),
        .compare_value   (compare_value),
        .regulation_mode (regulation_mode)
    );

`ifndef SYNTH
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (regulation_mode != hgph_pkg::MODE_PID))
            |-> ((duty_percent == '0) && (compare_value == '0)))
        else $error("off result carries nonzero duty or compare");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_percent <= hgph_pkg::FULL_DUTY))
        else $error("duty above full scale");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second sample taken while one is in flight");
`endif

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Hysteresis-gated PID heater controller testbench
// Streams temperature samples through the block under several register
// settings and checks duty, PWM compare value and regulation mode per sample
// against a cycle-free model of the control law kept in a scoreboard class.
// Both channels idle and stall at random; one phase runs back to back.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FULL_SCALE     = 100 << hgph_pkg::FRAC_BITS;
    localparam int TEMP_MAX       = 38400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 150;

    typedef struct {
        logic [hgph_pkg::DUTY_W-1:0] duty;
        logic [hgph_pkg::CMP_W-1:0]  cmp;
        hgph_pkg::mode_t             mode;
    } heater_result_t;

    class heater_checker;
        logic [hgph_pkg::TEMP_W-1:0]         setpoint;
        logic [hgph_pkg::TEMP_W-1:0]         upper;
        logic [hgph_pkg::TEMP_W-1:0]         lower;
        logic [hgph_pkg::GAIN_W-1:0]         kp;
        logic [hgph_pkg::GAIN_W-1:0]         ki;
        logic [hgph_pkg::GAIN_W-1:0]         kd;
        logic [hgph_pkg::LIMIT_W-1:0]        limit;
        logic [hgph_pkg::PERIOD_W-1:0]       period;
        logic signed [hgph_pkg::INTEG_W-1:0] integ_sum;
        logic signed [hgph_pkg::ERR_W-1:0]   last_err;
        heater_result_t                      expected_q[$];
        int                                  mismatches;
        int                                  checked;
        int                                  mode_seen[3];

        function new();
            setpoint   = 16'd7680;
            upper      = 16'd7680;
            lower      = 16'd7629;
            kp         = 16'd5120;
            ki         = 16'd512;
            kd         = 16'd2560;
            limit      = 15'd12800;
            period     = 16'd99;
            integ_sum  = '0;
            last_err   = '0;
            mismatches = 0;
            checked    = 0;
            mode_seen  = '{0, 0, 0};
        endfunction

        function void set_reg(hgph_pkg::cfg_idx_t idx,
                              logic [hgph_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                hgph_pkg::REG_REFERENCE: setpoint = data;
                hgph_pkg::REG_UPPER:     upper    = data;
                hgph_pkg::REG_LOWER:     lower    = data;
                hgph_pkg::REG_GAIN_P:    kp       = data;
                hgph_pkg::REG_GAIN_I:    ki       = data;
                hgph_pkg::REG_GAIN_D:    kd       = data;
                hgph_pkg::REG_LIMIT:     limit    = data[hgph_pkg::LIMIT_W-1:0];
                hgph_pkg::REG_PERIOD:    period   = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [hgph_pkg::TEMP_W-1:0] m);
            logic signed [hgph_pkg::ERR_W-1:0]   err;
            logic signed [hgph_pkg::ERR_W:0]     integ;
            logic signed [hgph_pkg::ERR_W:0]     lim_s;
            logic signed [hgph_pkg::DERIV_W-1:0] deriv;
            logic signed [hgph_pkg::ACC_W-1:0]   acc;
            logic signed [hgph_pkg::ACC_W-1:0]   scaled;
            logic [33:0]                         product;
            heater_result_t                      r;
            r.duty = '0;
            r.cmp  = '0;
            if (m >= upper)
            begin
                r.mode    = hgph_pkg::MODE_OFF_HIGH;
                integ_sum = '0;
                last_err  = '0;
            end
            else if (m <= lower)
            begin
                err   = $signed({1'b0, setpoint}) - $signed({1'b0, m});
                integ = integ_sum + (err >>> 1);
                lim_s = $signed({3'b000, limit});
                if (integ > lim_s)
                    integ = lim_s;
                if (integ < -lim_s)
                    integ = -lim_s;
                deriv = (err - last_err) * 2;
                acc   = $signed({1'b0, kp}) * err + $signed({1'b0, ki}) * integ
                      + $signed({1'b0, kd}) * deriv;
                if (acc > 0)
                begin
                    scaled = acc >>> hgph_pkg::FRAC_BITS;
                    r.duty = (scaled > FULL_SCALE) ? hgph_pkg::DUTY_W'(FULL_SCALE)
                                                   : scaled[hgph_pkg::DUTY_W-1:0];
                end
                product   = 34'(r.duty) * (34'(period) + 34'd1);
                r.cmp     = hgph_pkg::CMP_W'(product / FULL_SCALE);
                integ_sum = integ[hgph_pkg::INTEG_W-1:0];
                last_err  = err;
                r.mode    = hgph_pkg::MODE_PID;
            end
            else
            begin
                r.mode    = hgph_pkg::MODE_OFF_BAND;
                integ_sum = '0;
                last_err  = '0;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [hgph_pkg::DUTY_W-1:0] duty,
                                   logic [hgph_pkg::CMP_W-1:0] cmp,
                                   logic [1:0] mode);
            heater_result_t r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result duty=%0d cmp=%0d mode=%0d",
                             duty, cmp, mode);
                return;
            end
            r = expected_q.pop_front();
            checked++;
            mode_seen[r.mode]++;
            if (r.duty !== duty || r.cmp !== cmp || r.mode !== mode)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d expected duty=%0d cmp=%0d mode=%0d,",
                              " got duty=%0d cmp=%0d mode=%0d"},
                             checked, r.duty, r.cmp, r.mode, duty, cmp, mode);
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [hgph_pkg::TEMP_W-1:0]     measured_temp = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [hgph_pkg::DUTY_W-1:0]     duty_percent;
    logic [hgph_pkg::CMP_W-1:0]      compare_value;
    logic [1:0]                      regulation_mode;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [hgph_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hgph_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    heater_checker sb = new();
    int            gap_max = 14;
    int            stall_max = 14;
    int            stall_left = 0;
    int            idle_cycles = 0;
    int            settings = 1;

    hysteresis_gated_pid_heater i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .measured_temp   (measured_temp),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .duty_percent    (duty_percent),
        .compare_value   (compare_value),
        .regulation_mode (regulation_mode),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            sb.check_result(duty_percent, compare_value, regulation_mode);
            stall_left = $urandom_range(0, stall_max);
        end
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [hgph_pkg::TEMP_W-1:0] t);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        measured_temp <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(t);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input hgph_pkg::cfg_idx_t idx,
                             input logic [hgph_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(input logic [15:0] ref_t, input logic [15:0] up,
                                input logic [15:0] lo, input logic [15:0] gp,
                                input logic [15:0] gi, input logic [15:0] gd,
                                input logic [15:0] lim, input logic [15:0] per);
        drain();
        write_reg(hgph_pkg::REG_REFERENCE, ref_t);
        write_reg(hgph_pkg::REG_UPPER, up);
        write_reg(hgph_pkg::REG_LOWER, lo);
        write_reg(hgph_pkg::REG_GAIN_P, gp);
        write_reg(hgph_pkg::REG_GAIN_I, gi);
        write_reg(hgph_pkg::REG_GAIN_D, gd);
        write_reg(hgph_pkg::REG_LIMIT, lim);
        write_reg(hgph_pkg::REG_PERIOD, per);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic int clamp_temp(int v);
        if (v < 0)
            return 0;
        if (v > TEMP_MAX)
            return TEMP_MAX;
        return v;
    endfunction

    function automatic logic [hgph_pkg::TEMP_W-1:0] pick_temp(int span);
        int lo;
        int up;
        int k;
        int v;
        lo = int'(sb.lower);
        up = int'(sb.upper);
        k  = $urandom_range(0, 9);
        if (k < 6)
            v = lo - $urandom_range(0, span);
        else if (k == 6)
            v = lo + 1 + $urandom_range(0, 64);
        else if (k == 7)
            v = up + $urandom_range(0, 256);
        else if (k == 8)
        begin
            case ($urandom_range(0, 3))
                0:       v = lo;
                1:       v = up;
                2:       v = lo + 1;
                default: v = up - 1;
            endcase
        end
        else
            v = $urandom_range(0, TEMP_MAX);
        return hgph_pkg::TEMP_W'(clamp_temp(v));
    endfunction

    task automatic run_random_phase(input bit quiet);
        int         ref_t;
        int         up;
        int         lo;
        int         span;
        logic [15:0] lim;
        logic [15:0] per;
        ref_t = $urandom_range(0, TEMP_MAX);
        case ($urandom_range(0, 4))
            0:
            begin
                up = $urandom_range(0, TEMP_MAX);
                lo = $urandom_range(0, TEMP_MAX);
            end
            4:
            begin
                up = clamp_temp(ref_t - $urandom_range(0, 256));
                lo = clamp_temp(up + $urandom_range(0, 2000));
            end
            default:
            begin
                up = clamp_temp(ref_t + $urandom_range(0, 256));
                lo = clamp_temp(up - $urandom_range(1, 512));
            end
        endcase
        case ($urandom_range(0, 4))
            0:       lim = 16'd0;
            1:       lim = 16'h7FFF;
            2:       lim = 16'h8000 | 16'($urandom_range(0, 32767));
            default: lim = 16'($urandom_range(0, 32767));
        endcase
        case ($urandom_range(0, 3))
            0:       per = 16'd0;
            1:       per = 16'hFFFF;
            2:       per = 16'd99;
            default: per = 16'($urandom_range(0, 65535));
        endcase
        program_regs(16'(ref_t), 16'(up), 16'(lo), pick_gain(), pick_gain(), pick_gain(),
                     lim, per);
        gap_max   = quiet ? 0 : 14;
        stall_max = quiet ? 0 : 14;
        span      = 1 << $urandom_range(4, 12);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 2)
                drain();
            send_sample(pick_temp(span));
        end
        gap_max   = 14;
        stall_max = 14;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'd0);
        send_sample(16'd7629);
        send_sample(16'd7629);
        send_sample(16'd7500);
        send_sample(16'd7630);
        send_sample(16'd7679);
        send_sample(16'd7680);
        send_sample(16'd38400);
        send_sample(16'd7000);
        send_sample(16'd7600);

        program_regs(16'd38400, 16'd38400, 16'd38399, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'h7FFF, 16'hFFFF);
        send_sample(16'd0);
        send_sample(16'd38399);
        send_sample(16'd38400);
        send_sample(16'd38399);

        // crossed thresholds, zero integral limit, reference below some samples
        program_regs(16'd20000, 16'd1000, 16'd30000, 16'd5120, 16'd512, 16'd2560,
                     16'h8000, 16'd0);
        send_sample(16'd999);
        send_sample(16'd1000);
        send_sample(16'd25000);
        send_sample(16'd30000);
        send_sample(16'd30001);
        send_sample(16'd0);

        for (int p = 0; p < PHASES; p++)
            run_random_phase(p == 3);

        drain();
        repeat (20) @(posedge clk);
        $display("Checked %0d samples: %0d heating, %0d off above upper, %0d off in band",
                 sb.checked, sb.mode_seen[hgph_pkg::MODE_PID],
                 sb.mode_seen[hgph_pkg::MODE_OFF_HIGH],
                 sb.mode_seen[hgph_pkg::MODE_OFF_BAND]);
        $display("Register settings used: %0d, mismatches: %0d", settings, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
